// File: hdl/searchable_fifo_queue_defines.svh
// ---------------------------------------------------------------------------
// Searchable FIFO queue assertion macros
// Shared property shorthands for the concurrent checks of the queue.
// ---------------------------------------------------------------------------
`ifndef SEARCHABLE_FIFO_QUEUE_DEFINES_SVH
`define SEARCHABLE_FIFO_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SFQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/sfq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfq_pkg
// Types and codes shared by the queue controller, datapath and top level.
// ---------------------------------------------------------------------------
package sfq_pkg;

	// Fixed field widths of the transaction ports
	localparam int VAL_W = 32;
	localparam int POS_W = 4;
	localparam int OCC_W = 5;
	// Widest stored word, used for sign extension
	localparam int EXT_W = 64;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    capture;
		logic    mem_wr;
		logic    rd_head;
		logic    rd_slot;
		logic    pop_commit;
		logic    srch_init;
		logic    srch_step;
		logic    res_set_status;
		status_t res_status;
		logic    res_set_pos;
		logic    load_out;
	} dp_ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic full;
		logic match;
		logic last;
	} dp_sts_t;

endpackage

// File: hdl/sfq_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfq_dp
// Queue datapath: ring storage, pointers, search walker and result registers.
// ---------------------------------------------------------------------------
module sfq_dp
	import sfq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [1:0]              cmd,
	input  logic signed [VAL_W-1:0] value_in,
	input  dp_ctl_t                 ctl,
	output dp_sts_t                 sts,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] value_out,
	output logic [POS_W-1:0]        position,
	output logic [OCC_W-1:0]        occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         slot_q;
	logic [AW-1:0]         idx_q;
	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] key_q;
	status_t               res_status_q;
	logic [VAL_W-1:0]      res_value_q;
	logic [POS_W-1:0]      res_pos_q;
	status_t               out_status_q;
	logic [VAL_W-1:0]      out_value_q;
	logic [POS_W-1:0]      out_pos_q;
	logic [OCC_W-1:0]      out_occ_q;

	logic signed [EXT_W-1:0] key_wide;
	logic signed [EXT_W-1:0] pop_wide;
	logic [AW-1:0]           rd_addr;

	// Advance a ring slot, wrapping after the last entry
	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] slot);
		logic [AW-1:0] nxt;
		if (slot == AW'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = slot + AW'(1);
		end
		return nxt;
	endfunction

	// Widen the key to the stored width, and the popped word back to the port
	assign key_wide = EXT_W'(value_in);
	assign pop_wide = EXT_W'(signed'(rd_data_q));
	assign rd_addr  = ctl.rd_head ? head_q : slot_q;

	// Hold pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.mem_wr) begin
				tail_q  <= ring_next(tail_q);
				count_q <= count_q + CW'(1);
			end
			if (ctl.pop_commit) begin
				head_q  <= ring_next(head_q);
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Ring storage, single port with registered read
	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem_q[tail_q] <= key_q;
		end
		if (ctl.rd_head || ctl.rd_slot) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Capture the transaction, walk the search and build the result
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q        <= cmd_t'(cmd);
			key_q        <= key_wide[DATA_WIDTH-1:0];
			res_status_q <= ST_OK;
			res_value_q  <= '0;
			res_pos_q    <= '0;
		end
		if (ctl.res_set_status) begin
			res_status_q <= ctl.res_status;
		end
		if (ctl.pop_commit) begin
			res_value_q <= pop_wide[VAL_W-1:0];
		end
		if (ctl.srch_init) begin
			slot_q <= head_q;
			idx_q  <= '0;
		end
		if (ctl.srch_step) begin
			slot_q <= ring_next(slot_q);
			idx_q  <= idx_q + AW'(1);
		end
		if (ctl.res_set_pos) begin
			res_pos_q <= POS_W'(idx_q);
		end
		if (ctl.load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_pos_q    <= res_pos_q;
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	// Report status to the controller
	assign sts.cmd   = cmd_q;
	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CW'(DEPTH));
	assign sts.match = (rd_data_q == key_q);
	assign sts.last  = ((CW'(idx_q) + CW'(1)) == count_q);

	// Drive the result ports from the output register
	assign status    = out_status_q;
	assign value_out = out_value_q;
	assign position  = out_pos_q;
	assign occupancy = out_occ_q;

endmodule

// File: hdl/sfq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfq_ctrl
// Queue controller: sequences each transaction and owns both handshakes.
// ---------------------------------------------------------------------------
module sfq_ctrl
	import sfq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_ctl_t ctl,
	input  dp_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// Decode state into datapath commands
	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_RESULT;
				case (sts.cmd)
					CMD_PUSH: begin
						if (sts.full) begin
							ctl.res_set_status = 1'b1;
							ctl.res_status     = ST_FULL;
						end else begin
							ctl.mem_wr = 1'b1;
						end
					end
					CMD_POP: begin
						if (sts.empty) begin
							ctl.res_set_status = 1'b1;
							ctl.res_status     = ST_EMPTY;
						end else begin
							ctl.rd_head = 1'b1;
							state_nxt   = S_POP;
						end
					end
					CMD_SEARCH: begin
						if (sts.empty) begin
							ctl.res_set_status = 1'b1;
							ctl.res_status     = ST_EMPTY;
						end else begin
							ctl.srch_init = 1'b1;
							state_nxt     = S_SRCH_RD;
						end
					end
					default: begin
						// unused code: report ok, change nothing
					end
				endcase
			end
			S_POP: begin
				ctl.pop_commit = 1'b1;
				state_nxt      = S_RESULT;
			end
			S_SRCH_RD: begin
				ctl.rd_slot = 1'b1;
				state_nxt   = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (sts.match) begin
					ctl.res_set_pos = 1'b1;
					state_nxt       = S_RESULT;
				end else if (sts.last) begin
					ctl.res_set_status = 1'b1;
					ctl.res_status     = ST_NOT_FOUND;
					state_nxt          = S_RESULT;
				end else begin
					ctl.srch_step = 1'b1;
					state_nxt     = S_SRCH_RD;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					ctl.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hdl/searchable_fifo_queue.sv
// From acceptance to result valid, push, an unused code or an empty queue pass through
// S_EXEC and S_RESULT; pop adds S_POP; a search adds an S_SRCH_RD and S_SRCH_CMP pair
// for each entry that it compares, since the storage read is registered.
// The next transaction is taken in the cycle after the result is loaded; a stalled
// result lets at most one more transaction in.
// Reset (arst_n, asynchronous) empties the queue; stored words are not cleared.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// searchable_fifo_queue
// Bounded ring FIFO of signed words with push, pop and search-by-key.
// ---------------------------------------------------------------------------
`include "searchable_fifo_queue_defines.svh"

module searchable_fifo_queue
	import sfq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              cmd,
	input  logic signed [VAL_W-1:0] value_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] value_out,
	output logic [POS_W-1:0]        position,
	output logic [OCC_W-1:0]        occupancy
);

	dp_ctl_t ctl;
	dp_sts_t sts;

	// Sequence each transaction
	sfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	// Storage, pointers and result registers
	sfq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value_in  (value_in),
		.ctl       (ctl),
		.sts       (sts),
		.status    (status),
		.value_out (value_out),
		.position  (position),
		.occupancy (occupancy)
	);

	// Busy after every accepted transaction
	`SFQ_ASSERT_NEXT(a_busy_next, clk, arst_n, in_valid && !in_stall, in_stall, "not busy")
	// Never overwrite a pending result
	`SFQ_ASSERT_IMPLIES(a_load_free, clk, arst_n, ctl.load_out, !out_valid || !out_stall, "overwrite")
	// Never write into a full ring
	`SFQ_ASSERT_IMPLIES(a_push_room, clk, arst_n, ctl.mem_wr, !sts.full, "push when full")

endmodule
